FILE: hw/rtl/dcr_pkg.sv
// Package for the distance constraint relaxation block: item structs, pipeline
// context structs, field widths and register codes.
// No dependencies; used by every file under hw/rtl.
package dcr_pkg;

    // Field widths of the items.
    localparam int POS_W      = 32;
    localparam int MASS_W     = 16;
    localparam int RL_W       = 31;
    localparam int K_W        = 16;
    localparam int LANES      = 4;

    // Internal widths.
    localparam int MAG_W      = 32;   // |second - first| per axis
    localparam int SQ_W       = 66;   // dx^2 + dy^2, padded to an even width
    localparam int ROOT_W     = 33;   // floor of the distance
    localparam int SQ_STEPS   = SQ_W / 2;
    localparam int SREM_W     = 36;   // square-root partial remainder
    localparam int ERR_W      = 35;   // rest_length - distance, signed
    localparam int EMAG_W     = 34;
    localparam int BASE_W     = ROOT_W + K_W;
    localparam int CP_W       = MAG_W + EMAG_W;
    localparam int SH_W       = MASS_W + 1;
    localparam int SCALE_BITS = 7;    // factor 128 of the correction
    localparam int SHM_W      = MASS_W + SCALE_BITS;
    localparam int NUM_W      = CP_W + SHM_W;
    localparam int DEN_W      = BASE_W + SH_W;
    localparam int Q_W        = 41;   // quotient bits kept before the limit
    localparam int SUM_W      = 43;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS   = 2'd1;
    localparam logic [K_W-1:0]       K_RESET         = 16'd77;

    // Largest correction magnitude, 2^40.
    localparam logic [Q_W-1:0] CORR_LIMIT = {1'b1, {(Q_W-1){1'b0}}};

    // Lane order of the four corrected coordinates.
    localparam int LANE_FX = 0;
    localparam int LANE_FY = 1;
    localparam int LANE_SX = 2;
    localparam int LANE_SY = 3;

    typedef struct packed {
        logic signed [POS_W-1:0] first_x;
        logic signed [POS_W-1:0] first_y;
        logic signed [POS_W-1:0] second_x;
        logic signed [POS_W-1:0] second_y;
        logic [MASS_W-1:0]       first_mass;
        logic [MASS_W-1:0]       second_mass;
        logic                    first_pinned;
        logic                    second_pinned;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] new_first_x;
        logic signed [POS_W-1:0] new_first_y;
        logic signed [POS_W-1:0] new_second_x;
        logic signed [POS_W-1:0] new_second_y;
        logic                    degenerate;
    } t_out_item;

    typedef logic [LANES-1:0][POS_W-1:0] t_pos4;

    // Context carried along the square-root chain.
    typedef struct packed {
        t_pos4             pos;
        logic [MASS_W-1:0] m1;
        logic [MASS_W-1:0] m2;
        logic              p1;
        logic              p2;
        logic              neg_x;
        logic              neg_y;
        logic [MAG_W-1:0]  mag_x;
        logic [MAG_W-1:0]  mag_y;
    } t_sq_ctx;

    // Context carried along the divider chain.
    typedef struct packed {
        t_pos4            pos;
        logic [LANES-1:0] en;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
        logic             degen;
    } t_dv_ctx;

    typedef logic [LANES-1:0][DEN_W-1:0] t_rem4;
    typedef logic [LANES-1:0][Q_W-1:0]   t_q4;

endpackage

FILE: hw/rtl/dcr_sqrt_cell.sv
// One cell of the square-root chain: settles one root bit per item.
// Depends on dcr_pkg.
module dcr_sqrt_cell
    import dcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [SREM_W-1:0] i_rem,
    input  logic [ROOT_W-1:0] i_root,
    input  logic [SQ_W-1:0]   i_rad,
    input  t_sq_ctx           i_ctx,
    output logic              o_vld,
    output logic [SREM_W-1:0] o_rem,
    output logic [ROOT_W-1:0] o_root,
    output logic [SQ_W-1:0]   o_rad,
    output t_sq_ctx           o_ctx
);

    logic              r_vld;
    logic [SREM_W-1:0] r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [SQ_W-1:0]   r_rad;
    t_sq_ctx           r_ctx;

    logic [SREM_W+1:0] rem2;
    logic [SREM_W+1:0] trial;
    logic              ge;
    logic [SREM_W-1:0] n_rem;

    // Bring down the next two radicand bits and try the root bit as one.
    always_comb begin
        rem2  = {i_rem, i_rad[SQ_W-1 -: 2]};
        trial = {{(SREM_W-ROOT_W){1'b0}}, i_root, 2'b01};
        ge    = (rem2 >= trial);
        n_rem = ge ? SREM_W'(rem2 - trial) : SREM_W'(rem2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= {i_root[ROOT_W-2:0], ge};
        r_rad  <= {i_rad[SQ_W-3:0], 2'b00};
        r_ctx  <= i_ctx;
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;
    assign o_ctx  = r_ctx;

endmodule

FILE: hw/rtl/dcr_div_cell.sv
// One cell of the divider chain: settles one quotient bit in each of the four
// lanes, which share one divisor. Depends on dcr_pkg.
module dcr_div_cell
    import dcr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [DEN_W-1:0] i_den,
    input  t_rem4            i_rem,
    input  t_q4              i_nlo,
    input  t_q4              i_q,
    input  t_dv_ctx          i_ctx,
    output logic             o_vld,
    output logic [DEN_W-1:0] o_den,
    output t_rem4            o_rem,
    output t_q4              o_nlo,
    output t_q4              o_q,
    output t_dv_ctx          o_ctx
);

    logic             r_vld;
    logic [DEN_W-1:0] r_den;
    t_rem4            r_rem;
    t_q4              r_nlo;
    t_q4              r_q;
    t_dv_ctx          r_ctx;

    logic [LANES-1:0][DEN_W:0] rem2;
    logic [LANES-1:0]          ge;
    t_rem4                     n_rem;
    t_q4                       n_nlo;
    t_q4                       n_q;

    // Restoring division step in every lane.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            rem2[l]  = {i_rem[l], i_nlo[l][Q_W-1]};
            ge[l]    = (rem2[l] >= {1'b0, i_den});
            n_rem[l] = ge[l] ? DEN_W'(rem2[l] - {1'b0, i_den}) : DEN_W'(rem2[l]);
            n_nlo[l] = {i_nlo[l][Q_W-2:0], 1'b0};
            n_q[l]   = {i_q[l][Q_W-2:0], ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den <= i_den;
        r_rem <= n_rem;
        r_nlo <= n_nlo;
        r_q   <= n_q;
        r_ctx <= i_ctx;
    end

    assign o_vld = r_vld;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_nlo = r_nlo;
    assign o_q   = r_q;
    assign o_ctx = r_ctx;

endmodule

FILE: hw/rtl/distance_constraint_relax.sv
// Channel   Handshake                    Payload
// input     i_start / o_busy             i_item (t_in_item)
// result    o_res_strobe                 o_res (t_out_item)
// config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Fully pipelined: one item is accepted every cycle and o_busy stays low.
// Each item passes through the 33-cell square-root chain and the 41-cell
// divider chain plus seven stages before its result appears.
// Sync reset clears valid flags and rest length, sets stiffness to K_RESET.
// The receiver cannot stall; a result is shown for one cycle only.
// Depends on dcr_pkg, dcr_sqrt_cell and dcr_div_cell.
module distance_constraint_relax
    import dcr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_in_item              i_item,
    output logic                  o_res_strobe,
    output t_out_item             o_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LATENCY = 3 + SQ_STEPS + 3 + Q_W + 1;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    logic [RL_W-1:0] r_rest;
    logic [K_W-1:0]  r_stiff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest  <= '0;
            r_stiff <= K_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_REST_LENGTH: r_rest  <= i_cfg_data[RL_W-1:0];
                CFG_STIFFNESS:   r_stiff <= i_cfg_data[K_W-1:0];
                default:         ;
            endcase
        end
    end

    // Stage 1: capture the accepted item.
    logic     r_s1_vld;
    t_in_item r_s1_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_s1_item <= i_item;
        end
    end

    // Stage 2: axis offsets and their magnitudes.
    logic              r_s2_vld;
    t_sq_ctx           r_s2_ctx;
    t_sq_ctx           n_s2_ctx;
    logic [MAG_W:0]    dx;
    logic [MAG_W:0]    dy;

    always_comb begin
        dx = {r_s1_item.second_x[POS_W-1], r_s1_item.second_x}
           - {r_s1_item.first_x[POS_W-1], r_s1_item.first_x};
        dy = {r_s1_item.second_y[POS_W-1], r_s1_item.second_y}
           - {r_s1_item.first_y[POS_W-1], r_s1_item.first_y};
        n_s2_ctx.pos[LANE_FX] = r_s1_item.first_x;
        n_s2_ctx.pos[LANE_FY] = r_s1_item.first_y;
        n_s2_ctx.pos[LANE_SX] = r_s1_item.second_x;
        n_s2_ctx.pos[LANE_SY] = r_s1_item.second_y;
        n_s2_ctx.m1    = r_s1_item.first_mass;
        n_s2_ctx.m2    = r_s1_item.second_mass;
        n_s2_ctx.p1    = r_s1_item.first_pinned;
        n_s2_ctx.p2    = r_s1_item.second_pinned;
        n_s2_ctx.neg_x = dx[MAG_W];
        n_s2_ctx.neg_y = dy[MAG_W];
        n_s2_ctx.mag_x = dx[MAG_W] ? MAG_W'(-dx) : dx[MAG_W-1:0];
        n_s2_ctx.mag_y = dy[MAG_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ctx <= n_s2_ctx;
    end

    // Stage 3: squared distance.
    logic              r_s3_vld;
    t_sq_ctx           r_s3_ctx;
    logic [SQ_W-1:0]   r_s3_sq;
    logic [2*MAG_W-1:0] sqx;
    logic [2*MAG_W-1:0] sqy;

    assign sqx = r_s2_ctx.mag_x * r_s2_ctx.mag_x;
    assign sqy = r_s2_ctx.mag_y * r_s2_ctx.mag_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_ctx <= r_s2_ctx;
        r_s3_sq  <= {2'b00, sqx} + {2'b00, sqy};
    end

    // Square-root chain, one root bit per cell.
    logic              sq_vld  [SQ_STEPS+1];
    logic [SREM_W-1:0] sq_rem  [SQ_STEPS+1];
    logic [ROOT_W-1:0] sq_root [SQ_STEPS+1];
    logic [SQ_W-1:0]   sq_rad  [SQ_STEPS+1];
    t_sq_ctx           sq_ctx  [SQ_STEPS+1];

    assign sq_vld[0]  = r_s3_vld;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = r_s3_sq;
    assign sq_ctx[0]  = r_s3_ctx;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        dcr_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (sq_vld[g]),
            .i_rem  (sq_rem[g]),
            .i_root (sq_root[g]),
            .i_rad  (sq_rad[g]),
            .i_ctx  (sq_ctx[g]),
            .o_vld  (sq_vld[g+1]),
            .o_rem  (sq_rem[g+1]),
            .o_root (sq_root[g+1]),
            .o_rad  (sq_rad[g+1]),
            .o_ctx  (sq_ctx[g+1])
        );
    end

    // Stage 4: length error, base divisor and offset-times-error products.
    t_sq_ctx           sc;
    logic [ROOT_W-1:0] root_dist;
    logic [ERR_W-1:0]  err;
    logic [EMAG_W-1:0] emag;
    logic [K_W-1:0]    kk;

    logic              r_s4_vld;
    t_pos4             r_s4_pos;
    logic              r_s4_p1;
    logic              r_s4_p2;
    logic [MASS_W-1:0] r_s4_m1;
    logic [MASS_W-1:0] r_s4_m2;
    logic              r_s4_negx;
    logic              r_s4_negy;
    logic              r_s4_degen;
    logic [BASE_W-1:0] r_s4_base;
    logic [CP_W-1:0]   r_s4_cpx;
    logic [CP_W-1:0]   r_s4_cpy;

    always_comb begin
        sc        = sq_ctx[SQ_STEPS];
        root_dist = sq_root[SQ_STEPS];
        err  = {{(ERR_W-RL_W){1'b0}}, r_rest} - {{(ERR_W-ROOT_W){1'b0}}, root_dist};
        emag = err[ERR_W-1] ? EMAG_W'(-err) : err[EMAG_W-1:0];
        kk   = (r_stiff == '0) ? K_W'(1) : r_stiff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= sq_vld[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_pos   <= sc.pos;
        r_s4_p1    <= sc.p1;
        r_s4_p2    <= sc.p2;
        r_s4_m1    <= (sc.m1 == '0) ? MASS_W'(1) : sc.m1;
        r_s4_m2    <= (sc.m2 == '0) ? MASS_W'(1) : sc.m2;
        r_s4_negx  <= sc.neg_x ^ err[ERR_W-1];
        r_s4_negy  <= sc.neg_y ^ err[ERR_W-1];
        r_s4_degen <= (root_dist == '0);
        r_s4_base  <= root_dist * kk;
        r_s4_cpx   <= sc.mag_x * emag;
        r_s4_cpy   <= sc.mag_y * emag;
    end

    // Stage 5: mass-weighted numerators and the shared divisor.
    logic              both_free;
    logic [MASS_W-1:0] share_f;
    logic [MASS_W-1:0] share_s;
    logic [SH_W-1:0]   share_den;
    logic              r_s5_vld;
    logic [DEN_W-1:0]  r_s5_den;
    logic [LANES-1:0][NUM_W-1:0] r_s5_num;
    t_dv_ctx           r_s5_ctx;

    always_comb begin
        both_free = !r_s4_p1 && !r_s4_p2;
        share_f   = both_free ? r_s4_m2 : MASS_W'(1);
        share_s   = both_free ? r_s4_m1 : MASS_W'(1);
        share_den = both_free ? ({1'b0, r_s4_m1} + {1'b0, r_s4_m2}) : SH_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_den <= r_s4_base * share_den;
        r_s5_num[LANE_FX] <= r_s4_cpx * {share_f, {SCALE_BITS{1'b0}}};
        r_s5_num[LANE_FY] <= r_s4_cpy * {share_f, {SCALE_BITS{1'b0}}};
        r_s5_num[LANE_SX] <= r_s4_cpx * {share_s, {SCALE_BITS{1'b0}}};
        r_s5_num[LANE_SY] <= r_s4_cpy * {share_s, {SCALE_BITS{1'b0}}};
        r_s5_ctx.pos   <= r_s4_pos;
        r_s5_ctx.en    <= {!r_s4_p2, !r_s4_p2, !r_s4_p1, !r_s4_p1};
        r_s5_ctx.neg   <= {r_s4_negy, r_s4_negx, r_s4_negy, r_s4_negx};
        r_s5_ctx.ovf   <= '0;
        r_s5_ctx.degen <= r_s4_degen;
    end

    // Stage 6: detect quotients beyond the kept width and seed the divider.
    logic             r_s6_vld;
    logic [DEN_W-1:0] r_s6_den;
    t_rem4            r_s6_rem;
    t_q4              r_s6_nlo;
    t_dv_ctx          r_s6_ctx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_den       <= r_s5_den;
        r_s6_ctx.pos   <= r_s5_ctx.pos;
        r_s6_ctx.en    <= r_s5_ctx.en;
        r_s6_ctx.neg   <= r_s5_ctx.neg;
        r_s6_ctx.degen <= r_s5_ctx.degen;
        for (int l = 0; l < LANES; l++) begin
            r_s6_ctx.ovf[l] <= ({{(DEN_W-NUM_W+Q_W){1'b0}}, r_s5_num[l][NUM_W-1:Q_W]}
                                >= r_s5_den);
            r_s6_rem[l] <= {{(DEN_W-NUM_W+Q_W){1'b0}}, r_s5_num[l][NUM_W-1:Q_W]};
            r_s6_nlo[l] <= r_s5_num[l][Q_W-1:0];
        end
    end

    // Divider chain, one quotient bit per cell.
    logic             dv_vld [Q_W+1];
    logic [DEN_W-1:0] dv_den [Q_W+1];
    t_rem4            dv_rem [Q_W+1];
    t_q4              dv_nlo [Q_W+1];
    t_q4              dv_q   [Q_W+1];
    t_dv_ctx          dv_ctx [Q_W+1];

    assign dv_vld[0] = r_s6_vld;
    assign dv_den[0] = r_s6_den;
    assign dv_rem[0] = r_s6_rem;
    assign dv_nlo[0] = r_s6_nlo;
    assign dv_q[0]   = '0;
    assign dv_ctx[0] = r_s6_ctx;

    for (genvar g = 0; g < Q_W; g++) begin : g_div
        dcr_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (dv_vld[g]),
            .i_den  (dv_den[g]),
            .i_rem  (dv_rem[g]),
            .i_nlo  (dv_nlo[g]),
            .i_q    (dv_q[g]),
            .i_ctx  (dv_ctx[g]),
            .o_vld  (dv_vld[g+1]),
            .o_den  (dv_den[g+1]),
            .o_rem  (dv_rem[g+1]),
            .o_nlo  (dv_nlo[g+1]),
            .o_q    (dv_q[g+1]),
            .o_ctx  (dv_ctx[g+1])
        );
    end

    // Stage 7: limit each correction, apply it and saturate.
    t_dv_ctx                       fc;
    logic [LANES-1:0][Q_W-1:0]     corr;
    logic [LANES-1:0][SUM_W-1:0]   sum;
    logic [LANES-1:0][POS_W-1:0]   sat;
    logic                          add_it;
    logic                          r_strobe;
    t_out_item                     r_res;

    always_comb begin
        fc = dv_ctx[Q_W];
        for (int l = 0; l < LANES; l++) begin
            corr[l] = (fc.ovf[l] || (dv_q[Q_W][l] > CORR_LIMIT)) ? CORR_LIMIT
                                                                 : dv_q[Q_W][l];
            // The first point moves against the offset, the second with it.
            add_it = (l >= LANE_SX) ^ fc.neg[l];
            if (fc.en[l] && !fc.degen) begin
                sum[l] = add_it
                    ? {{(SUM_W-POS_W){fc.pos[l][POS_W-1]}}, fc.pos[l]}
                      + {{(SUM_W-Q_W){1'b0}}, corr[l]}
                    : {{(SUM_W-POS_W){fc.pos[l][POS_W-1]}}, fc.pos[l]}
                      - {{(SUM_W-Q_W){1'b0}}, corr[l]};
            end else begin
                sum[l] = {{(SUM_W-POS_W){fc.pos[l][POS_W-1]}}, fc.pos[l]};
            end
            if (!sum[l][SUM_W-1] && (|sum[l][SUM_W-2:POS_W-1])) begin
                sat[l] = {1'b0, {(POS_W-1){1'b1}}};
            end else if (sum[l][SUM_W-1] && !(&sum[l][SUM_W-2:POS_W-1])) begin
                sat[l] = {1'b1, {(POS_W-1){1'b0}}};
            end else begin
                sat[l] = sum[l][POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= dv_vld[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.new_first_x  <= sat[LANE_FX];
        r_res.new_first_y  <= sat[LANE_FY];
        r_res.new_second_x <= sat[LANE_SX];
        r_res.new_second_y <= sat[LANE_SY];
        r_res.degenerate   <= fc.degen;
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    // Every accepted item yields a result strobe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_res_strobe)
        else $error("result strobe missing after fixed latency");

    // A zero root comes only from coinciding points.
    a_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sq_vld[SQ_STEPS] && (sq_root[SQ_STEPS] == '0)) |->
        ((sq_ctx[SQ_STEPS].mag_x == '0) && (sq_ctx[SQ_STEPS].mag_y == '0)))
        else $error("square-root chain returned zero for distinct points");

    // An item with the first point pinned, or a degenerate one, keeps first_x.
    a_hold_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (dv_vld[Q_W] && (!dv_ctx[Q_W].en[LANE_FX] || dv_ctx[Q_W].degen)) |=>
        (o_res.new_first_x == $past(dv_ctx[Q_W].pos[LANE_FX])))
        else $error("first point moved although it must stay");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for distance_constraint_relax: drives constraint items,
// predicts each corrected pair in wide integer arithmetic and compares every result.
// Depends on dcr_pkg and the distance_constraint_relax RTL.
`timescale 1ns / 100ps

module testbench;
    import dcr_pkg::*;

    localparam int PIPE_DEPTH = 81;
    localparam logic [63:0] MOVE_LIMIT = 64'h100_0000_0000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_in_item              i_item;
    logic                  o_res_strobe;
    t_out_item             o_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor copies of the two registers.
    logic [RL_W-1:0] rest_len_q;
    logic [K_W-1:0]  stiff_q;

    t_out_item pair_q[$];
    int        err_count;
    bit        no_gaps;

    distance_constraint_relax dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_item       (i_item),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock and run limit.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Signed move along one axis: trunc(c * err * 128 * share / (base * total)), limited.
    function automatic logic signed [63:0] axis_move(logic signed [63:0] c,
                                                     logic signed [63:0] err,
                                                     logic [63:0] share,
                                                     logic [63:0] base,
                                                     logic [63:0] total);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [63:0]  m;
        if (c == 0 || err == 0) return 0;
        num = 128'(abs64(c)) * 128'(abs64(err)) * 128'(share * 128);
        den = 128'(base) * 128'(total);
        quo = num / den;
        m = (quo > 128'(MOVE_LIMIT)) ? MOVE_LIMIT : quo[63:0];
        return ((c < 0) != (err < 0)) ? -$signed(m) : $signed(m);
    endfunction

    // Expected corrected pair for one constraint item.
    function automatic t_out_item relax_pair(t_in_item it);
        logic signed [63:0] fx, fy, sx, sy, dx, dy, err;
        logic signed [63:0] nfx, nfy, nsx, nsy;
        logic [127:0] sq;
        logic [127:0] cand;
        logic [63:0]  root_dist, k, m1, m2, base;
        t_out_item r;
        fx = it.first_x;
        fy = it.first_y;
        sx = it.second_x;
        sy = it.second_y;
        k  = (stiff_q == 0) ? 64'd1 : 64'(stiff_q);
        m1 = (it.first_mass == 0) ? 64'd1 : 64'(it.first_mass);
        m2 = (it.second_mass == 0) ? 64'd1 : 64'(it.second_mass);
        dx = sx - fx;
        dy = sy - fy;
        sq = 128'(abs64(dx)) * 128'(abs64(dx)) + 128'(abs64(dy)) * 128'(abs64(dy));
        root_dist = 0;
        for (int b = 33; b >= 0; b--) begin
            cand = 128'(root_dist | (64'd1 << b));
            if (cand * cand <= sq) root_dist = cand[63:0];
        end
        nfx = fx;
        nfy = fy;
        nsx = sx;
        nsy = sy;
        r.degenerate = (root_dist == 0);
        if (root_dist != 0) begin
            err  = $signed(64'(rest_len_q)) - $signed(root_dist);
            base = root_dist * k;
            if (!it.first_pinned && !it.second_pinned) begin
                nfx = fx - axis_move(dx, err, m2, base, m1 + m2);
                nfy = fy - axis_move(dy, err, m2, base, m1 + m2);
                nsx = sx + axis_move(dx, err, m1, base, m1 + m2);
                nsy = sy + axis_move(dy, err, m1, base, m1 + m2);
            end else if (!it.first_pinned) begin
                nfx = fx - axis_move(dx, err, 1, base, 1);
                nfy = fy - axis_move(dy, err, 1, base, 1);
            end else if (!it.second_pinned) begin
                nsx = sx + axis_move(dx, err, 1, base, 1);
                nsy = sy + axis_move(dy, err, 1, base, 1);
            end
        end
        r.new_first_x  = clamp32(nfx);
        r.new_first_y  = clamp32(nfy);
        r.new_second_x = clamp32(nsx);
        r.new_second_y = clamp32(nsy);
        return r;
    endfunction

    // Record accepted items and register writes, and check each result.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            rest_len_q <= '0;
            stiff_q    <= K_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_REST_LENGTH: rest_len_q <= i_cfg_data[RL_W-1:0];
                    CFG_STIFFNESS:   stiff_q <= i_cfg_data[K_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !o_busy) pair_q.push_back(relax_pair(i_item));
            if (o_res_strobe) begin
                if (pair_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_res);
                    err_count++;
                end else begin
                    want = pair_q.pop_front();
                    if (want.new_first_x !== o_res.new_first_x)
                        $display("%0t: new_first_x exp %h got %h", $time,
                                 want.new_first_x, o_res.new_first_x);
                    if (want.new_first_y !== o_res.new_first_y)
                        $display("%0t: new_first_y exp %h got %h", $time,
                                 want.new_first_y, o_res.new_first_y);
                    if (want.new_second_x !== o_res.new_second_x)
                        $display("%0t: new_second_x exp %h got %h", $time,
                                 want.new_second_x, o_res.new_second_x);
                    if (want.new_second_y !== o_res.new_second_y)
                        $display("%0t: new_second_y exp %h got %h", $time,
                                 want.new_second_y, o_res.new_second_y);
                    if (want.degenerate !== o_res.degenerate)
                        $display("%0t: degenerate exp %b got %b", $time,
                                 want.degenerate, o_res.degenerate);
                    if (want !== o_res) err_count++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one item; start stays high when the next item follows at once.
    task automatic send_item(t_in_item it);
        int gap;
        i_item  <= it;
        i_start <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Let the pipeline drain so that registers may be written.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pair_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_item make_item(logic signed [31:0] fx, logic signed [31:0] fy,
                                           logic signed [31:0] sx, logic signed [31:0] sy,
                                           logic [15:0] m1, logic [15:0] m2,
                                           logic p1, logic p2);
        t_in_item it;
        it.first_x = fx;
        it.first_y = fy;
        it.second_x = sx;
        it.second_y = sy;
        it.first_mass = m1;
        it.second_mass = m2;
        it.first_pinned = p1;
        it.second_pinned = p2;
        return it;
    endfunction

    // Random item: mostly nearby pairs where the correction is meaningful.
    function automatic t_in_item rand_item();
        t_in_item it;
        int mode;
        int span;
        mode = $urandom_range(0, 9);
        it = make_item($urandom, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                       $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        if (mode < 6) begin
            span = $urandom_range(4, 26);
            it.second_x = it.first_x + ($signed($urandom) >>> (31 - span));
            it.second_y = it.first_y + ($signed($urandom) >>> (31 - span));
        end else if (mode == 6) begin
            it.second_x = it.first_x;
            it.second_y = it.first_y;
        end
        if ($urandom_range(0, 7) == 0) it.first_mass = 16'($urandom_range(0, 2));
        if ($urandom_range(0, 7) == 0) it.second_mass = 16'($urandom_range(0, 2));
        return it;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_item(rand_item());
    endtask

    // Extremes of every field, coinciding points and each pin combination.
    task automatic test_directed();
        logic signed [31:0] mx;
        logic signed [31:0] mn;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        send_item(make_item(0, 0, 0, 0, 1, 1, 0, 0));
        send_item(make_item(mx, mx, mx, mx, 16'hffff, 16'hffff, 0, 0));
        send_item(make_item(mn, mn, mx, mx, 1, 16'hffff, 0, 0));
        send_item(make_item(mx, mn, mn, mx, 16'hffff, 1, 0, 0));
        send_item(make_item(mn, mn, mx, mx, 0, 0, 0, 0));
        send_item(make_item(0, 0, 32'h10000, 0, 1, 1, 0, 0));
        send_item(make_item(0, 0, 1, 1, 1, 1, 0, 0));
        send_item(make_item(0, 0, 32'h30000, 32'h40000, 3, 5, 1, 0));
        send_item(make_item(0, 0, 32'h30000, 32'h40000, 3, 5, 0, 1));
        send_item(make_item(0, 0, 32'h30000, 32'h40000, 3, 5, 1, 1));
        send_item(make_item(5, 5, 5, 5, 3, 5, 1, 1));
        send_item(make_item(mx, 0, mx, 0, 2, 2, 1, 0));
        send_item(make_item(mn, mx, mx, mn, 0, 7, 1, 0));
        send_item(make_item(-32'sh10000, 32'sh20000, 32'sh10000, -32'sh20000, 9, 0,
                            0, 1));
        send_item(make_item(mx, mx, mx - 1, mx, 1, 1, 0, 0));
        send_item(make_item(mn, mn, mn + 1, mn + 1, 1, 1, 0, 0));
    endtask

    // Several register settings, extremes included, each followed by random items.
    task automatic test_settings();
        write_reg(CFG_REST_LENGTH, 32'h0001_0000);
        write_reg(CFG_STIFFNESS, 32'h0000_0100);
        test_directed();
        run_random(150);
        write_reg(CFG_REST_LENGTH, 32'hffff_ffff);
        write_reg(CFG_STIFFNESS, 32'h0000_0001);
        test_directed();
        run_random(150);
        write_reg(CFG_STIFFNESS, 32'hffff_0000);
        test_directed();
        run_random(100);
        write_reg(CFG_STIFFNESS, 32'h0000_ffff);
        write_reg(CFG_REST_LENGTH, 32'h8000_0000);
        run_random(100);
    endtask

    // Writes to unused indexes must leave the registers alone.
    task automatic test_spare_index();
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, 32'hffff_ffff);
        run_random(60);
    endtask

    // Random settings with random items, some stretches without gaps.
    task automatic test_random();
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_REST_LENGTH, ($urandom_range(0, 1) == 0) ? $urandom
                                                                   : ($urandom >> 10));
            write_reg(CFG_STIFFNESS, ($urandom_range(0, 3) == 0) ? $urandom
                                                                 : $urandom_range(0, 600));
            no_gaps = (ph % 3 == 0);
            run_random(110);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        err_count   = 0;
        no_gaps     = 1'b0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Reset values of the registers first.
        test_directed();
        run_random(40);
        test_settings();
        test_spare_index();
        test_random();
        drain();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/dcr_pkg.sv
hw/rtl/dcr_sqrt_cell.sv
hw/rtl/dcr_div_cell.sv
hw/rtl/distance_constraint_relax.sv
tb/testbench.sv
